FILE: hdl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: hdl/spq_pkg.sv
// types and constants of the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

  localparam int PRIO_W        = 16;
  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  // operation codes carried in s_tuser; the unused code acts as peek
  typedef enum logic [1:0] {
    OP_PEEK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // what a cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_NEW   = 2'd1,
    CELL_LOAD_LEFT  = 2'd2,
    CELL_LOAD_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic                      head_valid;
    logic signed [PRIO_W-1:0]  head_priority;
    logic signed [DATA_W-1:0]  head_data;
    logic [COUNT_W-1:0]        entry_count;
    logic                      insert_dropped;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/spq_cell.sv
// one slot of the queue row: holds an entry, compares it with a new one
// depends on spq_pkg
`default_nettype none

module spq_cell (
  input  wire               clk,
  input  spq_pkg::cell_op_t op,
  input  spq_pkg::entry_t   new_entry,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  input  wire               occupied,
  output spq_pkg::entry_t   q,
  output logic              ge
);
  import spq_pkg::*;

  // held entry stays ahead of an equal new one
  assign ge = occupied && (q.prio >= new_entry.prio);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD_NEW:   q <= new_entry;
      CELL_LOAD_LEFT:  q <= left_entry;
      CELL_LOAD_RIGHT: q <= right_entry;
      default:         q <= q;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/spq_out_buf.sv
// two-entry output buffer: output register plus skid stage
// depends on spq_pkg
`default_nettype none

module spq_out_buf (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  spq_pkg::result_t push_data,
  output logic             ready,
  output logic             out_valid,
  input  wire              out_ready,
  output spq_pkg::result_t out_data
);
  import spq_pkg::*;

  result_t skid_data;
  logic    skid_valid;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_data  <= push_data;
          out_valid <= push;
        end
      end else if (push) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue_top.sv
// top level of the sorted priority queue: cell row, fill counter, output buffer
// depends on spq_pkg, spq_cell, spq_out_buf and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// usage
// input channel s_*: one operation per transfer, kind in s_tuser
//   (peek, insert, remove head); insert carries priority and data in s_tdata
// output channel m_*: exactly one result per operation, in order: head
//   priority and data, entry count, head valid and insert dropped flags
// output: the result of an operation is held in the output register, or in the
//   skid stage while m_tready is low, and offered on m_* from there
// throughput: one operation per cycle while s_tready is high; every operation
//   finishes in a single compare-and-shift of the cell row, each cell comparing
//   against the new priority and loading the new entry, itself or a neighbor
// equal priorities leave in arrival order; an insert into a full queue is
//   dropped and flagged; remove on an empty queue changes nothing
// reset: the fill count and both channels clear, the queue is empty at once;
//   cell contents are not reset and only occupied cells are ever shown
// stall: while m_tready is low one more operation is taken into the skid
//   stage, then s_tready drops until the receiver catches up

module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [15:0] priority_req, [47:16] data
  input  wire  [47:0] s_tdata,
  // [1:0] opcode
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // [15:0] head_priority, [47:16] head_data, [52:48] entry_count, [55:53] zero
  output logic [55:0] m_tdata,
  // [0] head_valid, [1] insert_dropped
  output logic [1:0]  m_tuser
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          accept;
  logic          do_insert;
  logic          do_remove;
  logic          full;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  entry_t        new_entry;
  entry_t        cell_q [DEPTH];
  cell_op_t      cell_op [DEPTH];
  logic [DEPTH-1:0] occupied;
  logic [DEPTH-1:0] ge;
  entry_t        head_next;
  result_t       result;
  result_t       out_data;

  assign accept    = s_tvalid && s_tready;
  assign new_entry = '{prio: s_tdata[15:0], data: s_tdata[47:16]};
  assign full      = (count == CW'(DEPTH));
  assign do_insert = accept && (s_tuser == OP_INSERT) && !full;
  assign do_remove = accept && (s_tuser == OP_REMOVE) && (count != '0);

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_ge;

    assign occupied[i] = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_ge    = 1'b1;
    end else begin : g_inner
      assign left_entry = cell_q[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_q[i];
    end else begin : g_body
      assign right_entry = cell_q[i+1];
    end

    // insert: the first cell below the new priority takes it, later ones shift
    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (do_insert) begin
        if (ge[i]) begin
          cell_op[i] = CELL_HOLD;
        end else if (left_ge) begin
          cell_op[i] = CELL_LOAD_NEW;
        end else begin
          cell_op[i] = CELL_LOAD_LEFT;
        end
      end else if (do_remove) begin
        cell_op[i] = (i == DEPTH - 1) ? CELL_HOLD : CELL_LOAD_RIGHT;
      end
    end

    spq_cell u_cell (
      .clk         (clk),
      .op          (cell_op[i]),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .occupied    (occupied[i]),
      .q           (cell_q[i]),
      .ge          (ge[i])
    );
  end

  // fill count
  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + 1'b1;
    end else if (do_remove) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // head after this operation
  always_comb begin
    head_next = cell_q[0];
    if (do_insert && !ge[0]) begin
      head_next = new_entry;
    end else if (do_remove) begin
      head_next = cell_q[1];
    end
  end

  always_comb begin
    result.head_valid     = (count_next != '0);
    result.head_priority  = result.head_valid ? head_next.prio : '0;
    result.head_data      = result.head_valid ? head_next.data : '0;
    result.entry_count    = COUNT_W'(count_next);
    result.insert_dropped = accept && (s_tuser == OP_INSERT) && full;
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {3'b000, out_data.entry_count, out_data.head_data, out_data.head_priority};
  assign m_tuser = {out_data.insert_dropped, out_data.head_valid};

  // checks; the count is unknown before the first reset edge
  `ASSERT_ALWAYS(a_count_bound, rst || (count <= CW'(DEPTH)))
  `ASSERT_CLK(a_insert_grows, do_insert |=> count == $past(count) + 1'b1)
  `ASSERT_CLK(a_drop_keeps, (accept && s_tuser == OP_INSERT && full) |=> count == $past(count))
  `ASSERT_CLK(a_head_sorted, occupied[1] |-> cell_q[0].prio >= cell_q[1].prio)

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// self-checking bench for sorted_priority_queue_top: directed table, then random operations
// depends on spq_pkg and the rtl of the queue; its sorted list predicts each report not hand-typed
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int RAND_ITEMS  = 550;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;
  localparam int REPORT_MAX  = 10;
  localparam int TABLE_ROWS  = 25;

  // one line of the directed table
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] prio;
    logic [31:0]        data;
    bit                 typed;  // expected report written out by hand
    result_t            want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [15:0] priority_req, [47:16] data
  logic [47:0] s_tdata = '0;
  // [1:0] opcode
  logic [1:0]  s_tuser = OP_PEEK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [15:0] head_priority, [47:16] head_data, [52:48] entry_count, [55:53] zero
  logic [55:0] m_tdata;
  // [0] head_valid, [1] insert_dropped
  logic [1:0]  m_tuser;

  // hand-written expectation riding along with the operation on the input side
  bit      row_typed = 1'b0;
  result_t row_want  = '0;

  // idle rates in percent, changed between phases of the run
  int unsigned send_idle_pct  = 7;
  int unsigned recv_stall_pct = 47;

  // predictor state: held entries sorted, head at index 0
  logic signed [15:0] held_prio [DEPTH];
  logic [31:0]        held_data [DEPTH];
  int                 held_count = 0;

  // head reports still owed by the block, oldest first
  result_t head_reports_due [$];

  int n_sent       = 0;
  int n_results    = 0;
  int fault_count  = 0;
  int quiet_cycles = 0;

  sorted_priority_queue_top #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // apply one operation to the sorted list and return the report it should produce
  function automatic result_t apply_queue_op(input logic [1:0] op,
                                             input logic signed [15:0] prio,
                                             input logic [31:0] data);
    result_t r;
    int      slot;
    int      i;
    r = '0;
    if (op == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        // full: entry is thrown away, list untouched
        r.insert_dropped = 1'b1;
      end else begin
        // new entry goes behind everything of greater or equal priority
        slot = 0;
        while (slot < held_count && held_prio[slot] >= prio) slot++;
        for (i = held_count; i > slot; i--) begin
          held_prio[i] = held_prio[i-1];
          held_data[i] = held_data[i-1];
        end
        held_prio[slot] = prio;
        held_data[slot] = data;
        held_count++;
      end
    end else if (op == OP_REMOVE && held_count > 0) begin
      for (i = 0; i + 1 < held_count; i++) begin
        held_prio[i] = held_prio[i+1];
        held_data[i] = held_data[i+1];
      end
      held_count--;
    end
    // peek and the unused code fall through with no change
    if (held_count > 0) begin
      r.head_valid    = 1'b1;
      r.head_priority = held_prio[0];
      r.head_data     = held_data[0];
    end
    r.entry_count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  // directed table: empty-queue corners, extremes, ties, filling up and an
  // insert refused on a full queue
  function automatic table_row_t table_row(input int idx);
    table_row_t t;
    t = '{op: OP_PEEK, prio: '0, data: '0, typed: 1'b0, want: '0};
    case (idx)
      // empty queue right after reset: head reads as zero
      0: begin
        t.op = OP_PEEK; t.typed = 1'b1;
      end
      // remove on empty changes nothing
      1: begin
        t.op = OP_REMOVE; t.typed = 1'b1;
      end
      // unused code acts like peek, payload ignored
      2: begin
        t.op = OP_UNUSED; t.prio = -16'sd1; t.data = 32'hffff_ffff; t.typed = 1'b1;
      end
      3: begin
        t.op = OP_INSERT; t.prio = 16'sh7fff; t.data = 32'h7fff_ffff; t.typed = 1'b1;
        t.want = '{1'b1, 16'sh7fff, 32'h7fff_ffff, 5'd1, 1'b0};
      end
      4: begin
        t.op = OP_INSERT; t.prio = 16'sh8000; t.data = 32'h8000_0000; t.typed = 1'b1;
        t.want = '{1'b1, 16'sh7fff, 32'h7fff_ffff, 5'd2, 1'b0};
      end
      5: begin
        t.op = OP_INSERT; t.prio = 16'sd0; t.data = 32'h0;
      end
      // equal to the head: must land behind it
      6: begin
        t.op = OP_INSERT; t.prio = 16'sh7fff; t.data = 32'hffff_ffff;
      end
      7: t.op = OP_PEEK;
      // first max-priority entry leaves, its twin becomes head
      8: begin
        t.op = OP_REMOVE; t.typed = 1'b1;
        t.want = '{1'b1, 16'sh7fff, 32'hffff_ffff, 5'd3, 1'b0};
      end
      // fill the remaining slots below the head
      9:  begin t.op = OP_INSERT; t.prio = 16'sd1;      t.data = 32'h0000_0001; end
      10: begin t.op = OP_INSERT; t.prio = -16'sd1;     t.data = 32'hffff_fffe; end
      11: begin t.op = OP_INSERT; t.prio = 16'sh7ffe;   t.data = 32'h5555_5555; end
      12: begin t.op = OP_INSERT; t.prio = 16'sh8001;   t.data = 32'haaaa_aaaa; end
      13: begin t.op = OP_INSERT; t.prio = 16'sd100;    t.data = 32'h1234_5678; end
      14: begin t.op = OP_INSERT; t.prio = -16'sd100;   t.data = 32'h8765_4321; end
      15: begin t.op = OP_INSERT; t.prio = 16'sd0;      t.data = 32'h0000_00a0; end
      16: begin t.op = OP_INSERT; t.prio = 16'sd0;      t.data = 32'h0000_00a1; end
      17: begin t.op = OP_INSERT; t.prio = 16'sd5;      t.data = 32'h0f0f_0f0f; end
      18: begin t.op = OP_INSERT; t.prio = 16'sd5;      t.data = 32'hf0f0_f0f0; end
      19: begin t.op = OP_INSERT; t.prio = 16'sh8000;   t.data = 32'h0000_0002; end
      20: begin t.op = OP_INSERT; t.prio = 16'sd256;    t.data = 32'hdead_0001; end
      21: begin t.op = OP_INSERT; t.prio = -16'sd256;   t.data = 32'hdead_0002; end
      // full: even a top-priority insert is refused and flagged
      22: begin
        t.op = OP_INSERT; t.prio = 16'sh7fff; t.data = 32'h1234_5678; t.typed = 1'b1;
        t.want = '{1'b1, 16'sh7fff, 32'hffff_ffff, 5'd16, 1'b1};
      end
      23: t.op = OP_REMOVE;
      default: begin
        t.op = OP_UNUSED; t.prio = 16'sh00ff; t.data = 32'h00ff_00ff;
      end
    endcase
    return t;
  endfunction

  // offer one operation, idling first at the current rate, and return once it
  // has been taken by the block
  task automatic send_op(input logic [1:0] op, input logic signed [15:0] prio,
                         input logic [31:0] data, input bit typed, input result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 48'({$urandom, $urandom});
      s_tuser  <= 2'($urandom);
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= op;
    s_tdata   <= {data, prio};
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // receiver stalls at random at the current rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // score results against the oldest expectation, then predict for any
  // operation taken at this edge (its report is registered and scored at a later edge)
  result_t got;
  result_t want_now;
  result_t predicted;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.head_valid     = m_tuser[0];
        got.insert_dropped = m_tuser[1];
        got.head_priority  = m_tdata[15:0];
        got.head_data      = m_tdata[47:16];
        got.entry_count    = m_tdata[52:48];
        n_results++;
        if (head_reports_due.size() == 0) begin
          if (fault_count < REPORT_MAX)
            $display("[%0t] result with nothing pending: valid=%b prio=%0d data=%h cnt=%0d drop=%b",
                     $realtime, got.head_valid, got.head_priority, got.head_data,
                     got.entry_count, got.insert_dropped);
          fault_count++;
        end else begin
          want_now = head_reports_due.pop_front();
          if (got !== want_now) begin
            if (fault_count < REPORT_MAX)
              $display({"[%0t] mismatch: valid %b/%b prio %0d/%0d data %h/%h ",
                        "count %0d/%0d drop %b/%b (expected/actual)"},
                       $realtime, want_now.head_valid, got.head_valid,
                       want_now.head_priority, got.head_priority,
                       want_now.head_data, got.head_data,
                       want_now.entry_count, got.entry_count,
                       want_now.insert_dropped, got.insert_dropped);
            fault_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predicted = apply_queue_op(s_tuser, s_tdata[15:0], s_tdata[47:16]);
        head_reports_due.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  // watchdog: too long without any transfer on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  table_row_t         row;
  int                 k;
  int unsigned        insert_pct;
  int unsigned        roll;
  logic [1:0]         rnd_op;
  logic signed [15:0] rnd_prio;
  logic [31:0]        rnd_data;

  initial begin
    insert_pct = 50;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, in the first idling phase
    for (k = 0; k < TABLE_ROWS; k++) begin
      row = table_row(k);
      send_op(row.op, row.prio, row.data, row.typed, row.want);
    end

    // random part: insert-heavy, balanced and remove-heavy stretches so the
    // queue swings between empty and full; priorities mostly crowded into a
    // few values to produce plenty of ties
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 3) begin
        send_idle_pct  = 47;
        recv_stall_pct = 7;
      end else if (k == 2 * RAND_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        rnd_op = OP_INSERT;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3)       rnd_op = OP_UNUSED;
        else if (roll < 15) rnd_op = OP_PEEK;
        else                rnd_op = OP_REMOVE;
      end
      case ($urandom_range(0, 9))
        0:       rnd_prio = 16'($urandom);
        1:       rnd_prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        default: rnd_prio = 16'($urandom_range(0, 7)) - 16'sd4;
      endcase
      rnd_data = $urandom;
      send_op(rnd_op, rnd_prio, rnd_data, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // drain, then a quiet tail to catch anything extra
    wait (n_results == n_sent);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && head_reports_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
